>>> hdl/ort_pkg.sv
`default_nettype none
package ort_pkg;
   localparam int DEPTH_DEF       = 4096;
   localparam int HANDLE_BITS_DEF = 16;
   localparam int RESET_DEPTH     = 4096;
   localparam int ID_W            = 32;
   localparam int CSR_W           = 13;
   localparam int FUNC_W          = 2;
   localparam int STAT_W          = 3;

   localparam logic [FUNC_W-1:0] FUNC_ISSUE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RESPONSE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TAKE     = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_BUSY     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
   localparam logic [STAT_W-1:0] STAT_DUP      = 3'd3;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

   typedef struct packed {
      logic id_we;
      logic hl_we;
      logic rd_en;
   } mem_ctl_type;
endpackage
`default_nettype wire

>>> hdl/outstanding_request_tracker_unit.sv
`default_nettype none
// Channel   | Ports                                   | Handshake
// request   | req_func, req_resp_id, req_resp_handle  | req_valid / req_stall
// response  | rsp_status .. rsp_ready_count           | rsp_valid / rsp_stall
// config    | csr_wr_data                             | csr_wr_en
// Issue, take and undefined functions finish in S_OUT; take first reads the slot
// memory once with a registered read port, via S_TAKE_RD.
// A response scans the slot id memory one slot at a time (read, compare),
// then writes one slot per cycle for each skipped slot and the match.
// Synchronous active-high reset; slot stores need no clearing pass.
// A new request is accepted while a result still waits under rsp_stall.
module outstanding_request_tracker_unit #(
   parameter int DEPTH       = ort_pkg::DEPTH_DEF,
   parameter int HANDLE_BITS = ort_pkg::HANDLE_BITS_DEF,
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W      = $clog2(DEPTH + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [ort_pkg::FUNC_W-1:0] req_func,
   input  wire logic [ort_pkg::ID_W-1:0]   req_resp_id,
   input  wire logic [HANDLE_BITS-1:0]     req_resp_handle,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [ort_pkg::STAT_W-1:0]      rsp_status,
   output logic [ort_pkg::ID_W-1:0]        rsp_out_id,
   output logic [HANDLE_BITS-1:0]          rsp_out_handle,
   output logic                            rsp_out_lost,
   output logic [CNT_W-1:0]                rsp_pending_count,
   output logic [CNT_W-1:0]                rsp_ready_count,
   input  wire logic                       csr_wr_en,
   input  wire logic [ort_pkg::CSR_W-1:0]  csr_wr_data
);
   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_RD      = 6'b000010,
      S_CMP     = 6'b000100,
      S_MARK    = 6'b001000,
      S_TAKE_RD = 6'b010000,
      S_OUT     = 6'b100000
   } state_type;

   localparam int RST_DEPTH = (ort_pkg::RESET_DEPTH > DEPTH) ? DEPTH : ort_pkg::RESET_DEPTH;

   state_type state_ff, state_in;
   logic [PTR_W-1:0] take_ptr_ff, take_ptr_in, issue_ptr_ff, issue_ptr_in;
   logic [PTR_W-1:0] match_ptr_ff, match_ptr_in, scan_ptr_ff, scan_ptr_in;
   logic [ort_pkg::ID_W-1:0] next_tag_ff, next_tag_in, rid_ff, rid_in;
   logic [CNT_W-1:0] in_flight_ff, in_flight_in, ready_held_ff, ready_held_in;
   logic [CNT_W-1:0] depth_ff, depth_in, scan_left_ff, scan_left_in;
   logic [CNT_W-1:0] scan_k_ff, scan_k_in;
   logic scan_ready_ff, scan_ready_in;
   logic [HANDLE_BITS-1:0] rh_ff, rh_in;
   logic [ort_pkg::STAT_W-1:0] res_status_ff, res_status_in;
   logic [ort_pkg::ID_W-1:0] res_id_ff, res_id_in;
   logic [HANDLE_BITS-1:0] res_handle_ff, res_handle_in;
   logic res_lost_ff, res_lost_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ort_pkg::STAT_W-1:0] rsp_status_ff;
   logic [ort_pkg::ID_W-1:0] rsp_id_ff;
   logic [HANDLE_BITS-1:0] rsp_handle_ff;
   logic rsp_lost_ff;
   logic [CNT_W-1:0] rsp_pend_ff, rsp_rdy_ff;

   logic accept, out_free, ring_full;
   logic [PTR_W-1:0] adv_src, adv_out, wr_addr, rd_addr;
   logic [CNT_W-1:0] adv_sum;
   logic [CNT_W:0] ring_used;
   logic [CNT_W-1:0] csr_depth;
   ort_pkg::mem_ctl_type mem_ctl;
   logic [ort_pkg::ID_W-1:0] mem_id;
   logic [HANDLE_BITS-1:0] mem_handle, wr_handle;
   logic mem_lost, wr_lost;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ring_used = (CNT_W+1)'(in_flight_ff) + (CNT_W+1)'(ready_held_ff);
   assign ring_full = ring_used >= (CNT_W+1)'(depth_ff);

   // Shared ring advance: one incrementer with wrap at the active depth.
   always_comb begin
      case (state_ff)
         S_CMP:     adv_src = scan_ptr_ff;
         S_MARK:    adv_src = match_ptr_ff;
         S_TAKE_RD: adv_src = take_ptr_ff;
         default:   adv_src = issue_ptr_ff;
      endcase
      adv_sum = CNT_W'(adv_src) + CNT_W'(1);
      adv_out = (adv_sum >= depth_ff) ? '0 : adv_sum[PTR_W-1:0];
   end

   always_comb begin
      if (csr_wr_data == '0) begin
         csr_depth = CNT_W'(1);
      end else if (32'(csr_wr_data) > 32'(DEPTH)) begin
         csr_depth = CNT_W'(DEPTH);
      end else begin
         csr_depth = CNT_W'(csr_wr_data);
      end
   end

   always_comb begin
      state_in      = state_ff;
      take_ptr_in   = take_ptr_ff;
      issue_ptr_in  = issue_ptr_ff;
      match_ptr_in  = match_ptr_ff;
      scan_ptr_in   = scan_ptr_ff;
      next_tag_in   = next_tag_ff;
      rid_in        = rid_ff;
      rh_in         = rh_ff;
      in_flight_in  = in_flight_ff;
      ready_held_in = ready_held_ff;
      depth_in      = depth_ff;
      scan_left_in  = scan_left_ff;
      scan_k_in     = scan_k_ff;
      scan_ready_in = scan_ready_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_handle_in = res_handle_ff;
      res_lost_in   = res_lost_ff;
      mem_ctl       = '0;
      wr_addr       = issue_ptr_ff;
      rd_addr       = take_ptr_ff;
      wr_handle     = '0;
      wr_lost       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rid_in        = req_resp_id;
               rh_in         = req_resp_handle;
               res_status_in = ort_pkg::STAT_OK;
               res_id_in     = '0;
               res_handle_in = '0;
               res_lost_in   = 1'b0;
               state_in      = S_OUT;
               case (req_func)
                  ort_pkg::FUNC_ISSUE: begin
                     if (ring_full) begin
                        res_status_in = ort_pkg::STAT_BUSY;
                     end else begin
                        mem_ctl.id_we = 1'b1;
                        res_id_in     = next_tag_ff;
                        next_tag_in   = next_tag_ff + ort_pkg::ID_W'(1);
                        issue_ptr_in  = adv_out;
                        in_flight_in  = in_flight_ff + CNT_W'(1);
                     end
                  end
                  ort_pkg::FUNC_RESPONSE: begin
                     scan_ptr_in   = match_ptr_ff;
                     scan_left_in  = in_flight_ff;
                     scan_k_in     = '0;
                     scan_ready_in = 1'b0;
                     state_in      = S_RD;
                  end
                  ort_pkg::FUNC_TAKE: begin
                     if (ready_held_ff == '0) begin
                        res_status_in = ort_pkg::STAT_EMPTY;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        state_in      = S_TAKE_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            rd_addr = scan_ptr_ff;
            if (scan_left_ff != '0) begin
               mem_ctl.rd_en = 1'b1;
               state_in      = S_CMP;
            end else if (!scan_ready_ff) begin
               // in-flight window exhausted: look among answered slots
               scan_ptr_in   = take_ptr_ff;
               scan_left_in  = ready_held_ff;
               scan_ready_in = 1'b1;
            end else begin
               res_status_in = ort_pkg::STAT_NOTFOUND;
               state_in      = S_OUT;
            end
         end
         S_CMP: begin
            if (mem_id == rid_ff) begin
               if (scan_ready_ff) begin
                  res_status_in = ort_pkg::STAT_DUP;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_MARK;
               end
            end else begin
               scan_ptr_in  = adv_out;
               scan_left_in = scan_left_ff - CNT_W'(1);
               scan_k_in    = scan_k_ff + CNT_W'(1);
               state_in     = S_RD;
            end
         end
         S_MARK: begin
            mem_ctl.hl_we = 1'b1;
            wr_addr       = match_ptr_ff;
            match_ptr_in  = adv_out;
            in_flight_in  = in_flight_ff - CNT_W'(1);
            ready_held_in = ready_held_ff + CNT_W'(1);
            if (scan_k_ff != '0) begin
               wr_lost   = 1'b1;
               scan_k_in = scan_k_ff - CNT_W'(1);
            end else begin
               wr_handle = rh_ff;
               state_in  = S_OUT;
            end
         end
         S_TAKE_RD: begin
            res_id_in     = mem_id;
            res_handle_in = mem_handle;
            res_lost_in   = mem_lost;
            take_ptr_in   = adv_out;
            ready_held_in = ready_held_ff - CNT_W'(1);
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_wr_en) begin
         depth_in      = csr_depth;
         take_ptr_in   = '0;
         issue_ptr_in  = '0;
         match_ptr_in  = '0;
         in_flight_in  = '0;
         ready_held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         take_ptr_ff   <= '0;
         issue_ptr_ff  <= '0;
         match_ptr_ff  <= '0;
         next_tag_ff   <= ort_pkg::ID_W'(1);
         in_flight_ff  <= '0;
         ready_held_ff <= '0;
         depth_ff      <= CNT_W'(RST_DEPTH);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         take_ptr_ff   <= take_ptr_in;
         issue_ptr_ff  <= issue_ptr_in;
         match_ptr_ff  <= match_ptr_in;
         next_tag_ff   <= next_tag_in;
         in_flight_ff  <= in_flight_in;
         ready_held_ff <= ready_held_in;
         depth_ff      <= depth_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff   <= scan_ptr_in;
      scan_left_ff  <= scan_left_in;
      scan_k_ff     <= scan_k_in;
      scan_ready_ff <= scan_ready_in;
      rid_ff        <= rid_in;
      rh_ff         <= rh_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_handle_ff <= res_handle_in;
      res_lost_ff   <= res_lost_in;
      if (state_ff == S_OUT && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_handle_ff <= res_handle_ff;
         rsp_lost_ff   <= res_lost_ff;
         rsp_pend_ff   <= in_flight_ff;
         rsp_rdy_ff    <= ready_held_ff;
      end
   end

   ort_slot_mem #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_mem (
      .clock     (clock),
      .ctl       (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_id     (next_tag_ff),
      .wr_handle (wr_handle),
      .wr_lost   (wr_lost),
      .rd_addr   (rd_addr),
      .rd_id     (mem_id),
      .rd_handle (mem_handle),
      .rd_lost   (mem_lost)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_id        = rsp_id_ff;
   assign rsp_out_handle    = rsp_handle_ff;
   assign rsp_out_lost      = rsp_lost_ff;
   assign rsp_pending_count = rsp_pend_ff;
   assign rsp_ready_count   = rsp_rdy_ff;
endmodule
`default_nettype wire

>>> hdl/ort_slot_mem.sv
`default_nettype none
module ort_slot_mem #(
   parameter int DEPTH       = ort_pkg::DEPTH_DEF,
   parameter int HANDLE_BITS = ort_pkg::HANDLE_BITS_DEF,
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire ort_pkg::mem_ctl_type     ctl,
   input  wire logic [PTR_W-1:0]         wr_addr,
   input  wire logic [ort_pkg::ID_W-1:0] wr_id,
   input  wire logic [HANDLE_BITS-1:0]   wr_handle,
   input  wire logic                     wr_lost,
   input  wire logic [PTR_W-1:0]         rd_addr,
   output logic [ort_pkg::ID_W-1:0]      rd_id,
   output logic [HANDLE_BITS-1:0]        rd_handle,
   output logic                          rd_lost
);
   logic [ort_pkg::ID_W-1:0] id_mem_ff [DEPTH];
   logic [HANDLE_BITS:0]     hl_mem_ff [DEPTH];
   logic [ort_pkg::ID_W-1:0] id_rd_ff;
   logic [HANDLE_BITS:0]     hl_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.id_we) begin
         id_mem_ff[wr_addr] <= wr_id;
      end
      if (ctl.hl_we) begin
         hl_mem_ff[wr_addr] <= {wr_lost, wr_handle};
      end
      if (ctl.rd_en) begin
         id_rd_ff <= id_mem_ff[rd_addr];
         hl_rd_ff <= hl_mem_ff[rd_addr];
      end
   end

   assign rd_id     = id_rd_ff;
   assign rd_handle = hl_rd_ff[HANDLE_BITS-1:0];
   assign rd_lost   = hl_rd_ff[HANDLE_BITS];
endmodule
`default_nettype wire

>>> hdl/ort_checker.sv
`default_nettype none
module ort_checker #(
   parameter int DEPTH       = ort_pkg::DEPTH_DEF,
   parameter int HANDLE_BITS = ort_pkg::HANDLE_BITS_DEF,
   localparam int CNT_W      = $clog2(DEPTH + 1)
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [ort_pkg::STAT_W-1:0] rsp_status,
   input wire logic [ort_pkg::ID_W-1:0]   rsp_out_id,
   input wire logic [HANDLE_BITS-1:0]     rsp_out_handle,
   input wire logic                       rsp_out_lost,
   input wire logic [CNT_W-1:0]           rsp_pending_count,
   input wire logic [CNT_W-1:0]           rsp_ready_count
);
   // Hold a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_id) && $stable(rsp_status))
      else $error("stalled result changed");

   // Fill never exceeds the ring.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((CNT_W+1)'(rsp_pending_count) + (CNT_W+1)'(rsp_ready_count))
                    <= (CNT_W+1)'(DEPTH))
      else $error("ring overfilled");

   // A lost entry carries no handle and was taken successfully.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_lost |-> rsp_out_handle == '0 && rsp_status == ort_pkg::STAT_OK)
      else $error("lost entry with handle");

   // Busy only with a nonempty ring; empty only with nothing ready.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ort_pkg::STAT_BUSY |->
         (rsp_pending_count != '0 || rsp_ready_count != '0))
      else $error("busy on empty ring");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ort_pkg::STAT_EMPTY |-> rsp_ready_count == '0)
      else $error("empty with ready entries");
endmodule

bind outstanding_request_tracker_unit ort_checker #(
   .DEPTH       (DEPTH),
   .HANDLE_BITS (HANDLE_BITS)
) u_ort_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_out_id        (rsp_out_id),
   .rsp_out_handle    (rsp_out_handle),
   .rsp_out_lost      (rsp_out_lost),
   .rsp_pending_count (rsp_pending_count),
   .rsp_ready_count   (rsp_ready_count)
);
`default_nettype wire
